// File: sv/krast_pkg.sv
// shared types and constants for the keyed range add/sum table
// no dependencies
package krast_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_ADD    = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2
  } status_t;

  typedef struct packed {
    logic             key_we;
    logic             val_we;
    logic             set_vld;
    logic             clr_vld;
    logic [IDX_W-1:0] addr;
  } wr_ctl_t;

endpackage

// File: sv/krast_store.sv
// entry storage: key and value memories with registered read,
// plus per-entry valid flags cleared at reset; uses krast_pkg
module krast_store import krast_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic             rd_vld,
  output logic [KEY_W-1:0] rd_key,
  output logic [VAL_W-1:0] rd_value,
  input  wr_ctl_t          wr,
  input  logic [KEY_W-1:0] wr_key,
  input  logic [VAL_W-1:0] wr_value
);

  logic [KEY_W-1:0]    key_mem [CAPACITY];
  logic [VAL_W-1:0]    val_mem [CAPACITY];
  logic [CAPACITY-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr.addr] <= wr_key;
    end
    if (wr.val_we) begin
      val_mem[wr.addr] <= wr_value;
    end
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.set_vld) begin
        vld[wr.addr] <= 1'b1;
      end
      if (wr.clr_vld) begin
        vld[wr.addr] <= 1'b0;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

endmodule

// File: sv/keyed_range_add_sum_table_top.sv
// top level of the keyed range add/sum table: control sequencer and output word register
// uses krast_pkg and krast_store
//
// Holds up to CAPACITY entries of a signed 32-bit key and a 64-bit value. Every input
// word (insert, delete range, add to range, query range sum) walks the whole entry
// memory through its single read port, one entry per cycle, with a registered read
// and write-back of changed entries behind the read; inserts are written at the
// end of the walk into the lowest free slot. A new word is taken as soon as the
// previous result sits in the output register. Values and sums wrap modulo
// 2^64; a reversed range touches nothing and sums to zero.
module keyed_range_add_sum_table_top import krast_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              op,
  input  logic signed [KEY_W-1:0] key_low,
  input  logic signed [KEY_W-1:0] key_high,
  input  logic signed [VAL_W-1:0] amount,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] range_sum,
  output logic [1:0]              status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                  state;
  op_t                     op_q;
  logic signed [KEY_W-1:0] lo_q;
  logic signed [KEY_W-1:0] hi_q;
  logic [VAL_W-1:0]        amount_q;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        count;
  logic                    p_vld;
  logic [IDX_W-1:0]        p_idx;
  logic                    dup;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;
  logic [VAL_W-1:0]        sum;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_vld;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_value;
  wr_ctl_t          wr;
  logic [VAL_W-1:0] wr_value;
  logic             hit;
  logic             out_free;
  logic             room;

  krast_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_vld   (rd_vld),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .wr       (wr),
    .wr_key   (lo_q),
    .wr_value (wr_value)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign room     = (count < CNT_W'(CAPACITY));
  assign rd_en    = (state == S_SCAN) && (cnt < CNT_W'(CAPACITY));
  assign rd_addr  = cnt[IDX_W-1:0];
  assign hit      = p_vld && rd_vld && ($signed(rd_key) >= lo_q) && ($signed(rd_key) <= hi_q);

  always_comb begin
    wr       = '0;
    wr.addr  = p_idx;
    wr_value = rd_value + amount_q;
    if (p_vld) begin
      case (op_q)
        OP_DELETE: begin
          wr.clr_vld = hit;
        end
        OP_ADD: begin
          wr.val_we = hit;
        end
        default: begin
        end
      endcase
    end
    if (state == S_DONE) begin
      wr_value = amount_q;
      wr.addr  = free_idx;
      if (out_free && op_q == OP_INSERT && !dup && room) begin
        wr.key_we  = 1'b1;
        wr.val_we  = 1'b1;
        wr.set_vld = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      count     <= '0;
      p_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= op_t'(op);
            lo_q       <= key_low;
            hi_q       <= key_high;
            amount_q   <= amount;
            cnt        <= '0;
            dup        <= 1'b0;
            free_found <= 1'b0;
            free_idx   <= '0;
            sum        <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          p_vld <= rd_en;
          p_idx <= rd_addr;
          if (rd_en) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (p_vld) begin
            case (op_q)
              OP_INSERT: begin
                if (rd_vld && rd_key == lo_q) begin
                  dup <= 1'b1;
                end
                if (!rd_vld && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= p_idx;
                end
              end
              OP_DELETE: begin
                if (hit) begin
                  count <= count - CNT_W'(1);
                end
              end
              OP_QUERY: begin
                if (hit) begin
                  sum <= sum + rd_value;
                end
              end
              default: begin
              end
            endcase
          end
          if (!rd_en && !p_vld) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            range_sum <= sum;
            if (op_q == OP_INSERT && dup) begin
              status <= ST_DUP;
            end else if (op_q == OP_INSERT && !room) begin
              status <= ST_FULL;
            end else begin
              status <= ST_OK;
            end
            if (op_q == OP_INSERT && !dup && room) begin
              count <= count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
